FILE: design/ihsp_pkg.sv
// ----------------------------------------------------------------------------
// ihsp_pkg: shared types and constants for the image header size probe
// Format codes, result record, and the signature byte tables.
// ----------------------------------------------------------------------------
package ihsp_pkg;

  typedef enum logic [1:0] {
    FmtNone = 2'd0,
    FmtWebp = 2'd1,
    FmtPng  = 2'd2,
    FmtJpeg = 2'd3
  } fmt_e;

  typedef struct packed {
    fmt_e        fmt;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

  localparam logic [7:0] JpegMarker = 8'hFF;
  localparam logic [7:0] JpegSoi    = 8'hD8;
  localparam logic [7:0] SofFirst   = 8'hC0;
  localparam logic [7:0] SofLast    = 8'hC3;

  localparam int unsigned PosBits = 5;
  localparam logic [PosBits-1:0] PosSat       = 5'd24;
  localparam logic [PosBits-1:0] MinFileBytes = 5'd12;
  localparam logic [PosBits-1:0] PngSigEnd    = 5'd8;
  localparam logic [PosBits-1:0] RiffEnd      = 5'd4;
  localparam logic [PosBits-1:0] WebpFirst    = 5'd8;
  localparam logic [PosBits-1:0] PngDimsFirst = 5'd16;
  localparam logic [PosBits-1:0] WalkFirst    = 5'd2;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] riff_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h52;
      2'd1:    r = 8'h49;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] webp_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h45;
      2'd2:    r = 8'h42;
      default: r = 8'h50;
    endcase
    return r;
  endfunction

endpackage

FILE: design/image_header_size_probe_top.sv
// ----------------------------------------------------------------------------
// image_header_size_probe_top: image format and pixel size probe
// Streams an image file one byte per beat and reports its format and size.
// ----------------------------------------------------------------------------
// Input channel: one file byte per beat with first/last marks (in_valid_i,
// in_stall_o). A first mark restarts the parse; after a last mark the next
// byte starts a new file even without a first mark.
// Output channel: one result beat per file, issued for the last byte
// (out_valid_o, out_stall_i): format, width and height.
// Result path: the last byte is taken into the input register, then the parse
// logic feeds the result register that presents the result beat.
// Throughput: one byte per cycle while out_stall_i holds no result, including
// back-to-back files; the parse state is updated from the registered byte.
// Stall: while a result is held by out_stall_i, the whole pipe holds and
// in_stall_o is high; nothing is dropped.
// Reset: clears the input and result valid flags and puts the parser in its
// cleared state, waiting for byte 0 of a file.
// ----------------------------------------------------------------------------
module image_header_size_probe_top import ihsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  image_format_o,
  output logic [31:0] pixel_width_o,
  output logic [31:0] pixel_height_o
);

  logic       advance;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;
  logic       out_valid_q;
  result_t    result;
  result_t    result_q;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q  <= in_valid_i;
      out_valid_q <= in_valid_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q   <= data_byte_i;
      first_q  <= first_byte_i;
      last_q   <= last_byte_i;
      result_q <= result;
    end
  end

  ihsp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance && in_valid_q),
    .data_byte_i  (byte_q),
    .first_byte_i (first_q),
    .last_byte_i  (last_q),
    .result_o     (result)
  );

  assign out_valid_o    = out_valid_q;
  assign image_format_o = result_q.fmt;
  assign pixel_width_o  = result_q.width;
  assign pixel_height_o = result_q.height;

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_q))
    else $error("held result changed");

  // input only stalls behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // formats without a probed size report zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_q.fmt == FmtNone || result_q.fmt == FmtWebp)
      |-> pixel_width_o == 32'd0 && pixel_height_o == 32'd0)
    else $error("size reported for unsized format");

  // JPEG sizes come from 16-bit fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_q.fmt == FmtJpeg
      |-> pixel_width_o[31:16] == 16'd0 && pixel_height_o[31:16] == 16'd0)
    else $error("JPEG size exceeds 16 bits");

  // a result beat rises only after a last byte held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && last_q))
    else $error("result without a last byte");

endmodule

FILE: design/ihsp_parser.sv
// ----------------------------------------------------------------------------
// ihsp_parser: per-byte header parser
// Holds the signature checks, PNG size bytes and the JPEG marker walk; updates
// them for one byte per enabled cycle and presents the result of a last byte.
// ----------------------------------------------------------------------------
module ihsp_parser import ihsp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  output result_t       result_o
);

  localparam logic [2:0] PhMark0   = 3'd0;
  localparam logic [2:0] PhMark1   = 3'd1;
  localparam logic [2:0] PhLenHi   = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhSkip    = 3'd4;
  localparam logic [2:0] PhSofSkip = 3'd5;
  localparam logic [2:0] PhDims    = 3'd6;
  localparam logic [2:0] PhGot     = 3'd7;

  logic [PosBits-1:0] pos_q, pos_d;
  logic               png_ok_q, png_ok_d;
  logic               webp_ok_q, webp_ok_d;
  logic               jpeg_ok_q, jpeg_ok_d;
  logic [63:0]        png_dims_q, png_dims_d;
  logic [2:0]         phase_q, phase_d;
  logic [15:0]        skip_q, skip_d;
  logic [7:0]         len_hi_q, len_hi_d;
  logic [31:0]        jpeg_dims_q, jpeg_dims_d;
  logic               walk_done_q, walk_done_d;

  always_comb begin
    logic [PosBits-1:0] pos;
    logic [15:0]        len;
    logic [7:0]         b;
    b   = data_byte_i;
    len = {len_hi_q, b};

    // a first mark restarts from the cleared state
    pos         = first_byte_i ? '0 : pos_q;
    png_ok_d    = first_byte_i ? 1'b1 : png_ok_q;
    webp_ok_d   = first_byte_i ? 1'b1 : webp_ok_q;
    jpeg_ok_d   = first_byte_i ? 1'b1 : jpeg_ok_q;
    png_dims_d  = first_byte_i ? '0 : png_dims_q;
    phase_d     = first_byte_i ? PhMark0 : phase_q;
    skip_d      = first_byte_i ? '0 : skip_q;
    len_hi_d    = first_byte_i ? '0 : len_hi_q;
    jpeg_dims_d = first_byte_i ? '0 : jpeg_dims_q;
    walk_done_d = first_byte_i ? 1'b0 : walk_done_q;
    len         = {len_hi_d, b};

    if (pos < PngSigEnd && b != png_sig_byte(pos[2:0])) png_ok_d = 1'b0;
    if (pos < RiffEnd && b != riff_byte(pos[1:0])) webp_ok_d = 1'b0;
    if (pos >= WebpFirst && pos < MinFileBytes && b != webp_byte(pos[1:0]))
      webp_ok_d = 1'b0;
    if (pos == 5'd0 && b != JpegMarker) jpeg_ok_d = 1'b0;
    if (pos == 5'd1 && b != JpegSoi) jpeg_ok_d = 1'b0;
    if (pos >= PngDimsFirst && pos < PosSat) png_dims_d = {png_dims_d[55:0], b};

    if (pos >= WalkFirst && !walk_done_d) begin
      unique case (phase_d)
        PhMark0: begin
          if (b != JpegMarker) begin
            walk_done_d = 1'b1;
            jpeg_dims_d = '0;
          end else begin
            phase_d = PhMark1;
          end
        end
        PhMark1: begin
          if (b >= SofFirst && b <= SofLast) begin
            skip_d  = 16'd3;
            phase_d = PhSofSkip;
          end else begin
            phase_d = PhLenHi;
          end
        end
        PhLenHi: begin
          len_hi_d = b;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          if (len < 16'd2) begin
            // bad segment length: stop without a size
            walk_done_d = 1'b1;
            phase_d     = PhMark0;
            jpeg_dims_d = '0;
          end else begin
            skip_d  = len - 16'd2;
            phase_d = (len != 16'd2) ? PhSkip : PhMark0;
          end
        end
        PhSkip: begin
          skip_d = skip_d - 16'd1;
          if (skip_d == 16'd0) phase_d = PhMark0;
        end
        PhSofSkip: begin
          skip_d = skip_d - 16'd1;
          if (skip_d == 16'd0) begin
            skip_d  = 16'd4;
            phase_d = PhDims;
          end
        end
        PhDims: begin
          jpeg_dims_d = {jpeg_dims_d[23:0], b};
          skip_d      = skip_d - 16'd1;
          if (skip_d == 16'd0) begin
            phase_d     = PhGot;
            walk_done_d = 1'b1;
          end
        end
        PhGot: walk_done_d = 1'b1;
      endcase
    end

    pos_d = (pos < PosSat) ? pos + 5'd1 : pos;

    result_o = '{fmt: FmtNone, width: '0, height: '0};
    if (pos_d >= MinFileBytes) begin
      if (webp_ok_d) begin
        result_o.fmt = FmtWebp;
      end else if (png_ok_d) begin
        result_o.fmt = FmtPng;
        if (pos_d >= PosSat) begin
          result_o.width  = png_dims_d[63:32];
          result_o.height = png_dims_d[31:0];
        end
      end else if (jpeg_ok_d) begin
        result_o.fmt = FmtJpeg;
        if (phase_d == PhGot) begin
          result_o.height = {16'd0, jpeg_dims_d[31:16]};
          result_o.width  = {16'd0, jpeg_dims_d[15:0]};
        end
      end
    end

    // the file is done: next byte starts fresh
    if (last_byte_i) begin
      pos_d       = '0;
      png_ok_d    = 1'b1;
      webp_ok_d   = 1'b1;
      jpeg_ok_d   = 1'b1;
      png_dims_d  = '0;
      phase_d     = PhMark0;
      skip_d      = '0;
      len_hi_d    = '0;
      jpeg_dims_d = '0;
      walk_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      png_ok_q    <= 1'b1;
      webp_ok_q   <= 1'b1;
      jpeg_ok_q   <= 1'b1;
      png_dims_q  <= '0;
      phase_q     <= PhMark0;
      skip_q      <= '0;
      len_hi_q    <= '0;
      jpeg_dims_q <= '0;
      walk_done_q <= 1'b0;
    end else if (en_i) begin
      pos_q       <= pos_d;
      png_ok_q    <= png_ok_d;
      webp_ok_q   <= webp_ok_d;
      jpeg_ok_q   <= jpeg_ok_d;
      png_dims_q  <= png_dims_d;
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      jpeg_dims_q <= jpeg_dims_d;
      walk_done_q <= walk_done_d;
    end
  end

endmodule

FILE: tb/image_header_size_probe_top_tb.sv
// ----------------------------------------------------------------------------
// image_header_size_probe_top_tb: self-checking bench for the size probe
// Streams whole image files byte by byte, predicts the format and pixel size
// of each file with an in-bench parser, and checks every result beat in order.
// Covers short files, WebP, PNG, JPEG marker walks, broken headers, framing
// without first or last marks, random idling, and a long output hold.
// ----------------------------------------------------------------------------
module image_header_size_probe_top_tb;
  import ihsp_pkg::*;

  localparam int StuckLimit = 1000;
  localparam int HoldCycles = 100;
  localparam int RandomBytes = 850;
  localparam int MinBytes = 12;
  localparam int PosCap = 24;
  localparam logic [63:0] PngMagic = 64'h89504E470D0A1A0A;
  localparam logic [31:0] RiffTag = 32'h52494646;
  localparam logic [31:0] WebpTag = 32'h57454250;

  typedef enum logic [2:0] {
    MarkFirst, MarkCode, LenHigh, LenLow, SegSkip, SofSkip, SofDims, SizeFound
  } walk_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  image_format_o;
  logic [31:0] pixel_width_o;
  logic [31:0] pixel_height_o;

  image_header_size_probe_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .image_format_o (image_format_o),
    .pixel_width_o  (pixel_width_o),
    .pixel_height_o (pixel_height_o)
  );

  // parser mirror state
  logic [4:0]  seen_cnt;
  bit          png_match;
  bit          webp_match;
  bit          jpeg_match;
  logic [63:0] png_size_bytes;
  walk_phase_e walk_st;
  logic [15:0] bytes_left;
  logic [7:0]  seg_len_hi;
  logic [31:0] sof_size;
  bit          walk_done;

  result_t     pending_reports[$];
  result_t     want;
  logic [7:0]  file_buf[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          stuck_cycles = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  task automatic clear_parse();
    seen_cnt = '0;
    png_match = 1'b1;
    webp_match = 1'b1;
    jpeg_match = 1'b1;
    png_size_bytes = '0;
    walk_st = MarkFirst;
    bytes_left = '0;
    seg_len_hi = '0;
    sof_size = '0;
    walk_done = 1'b0;
  endtask

  task automatic abandon_walk();
    walk_done = 1'b1;
    walk_st = MarkFirst;
    sof_size = '0;
  endtask

  task automatic walk_step(input logic [7:0] b);
    logic [15:0] seg_len;
    case (walk_st)
      MarkFirst: begin
        if (b != 8'hFF) abandon_walk();
        else walk_st = MarkCode;
      end
      MarkCode: begin
        if (b >= SofFirst && b <= SofLast) begin
          bytes_left = 16'd3;
          walk_st = SofSkip;
        end else begin
          walk_st = LenHigh;
        end
      end
      LenHigh: begin
        seg_len_hi = b;
        walk_st = LenLow;
      end
      LenLow: begin
        seg_len = {seg_len_hi, b};
        if (seg_len < 16'd2) begin
          abandon_walk();
        end else begin
          bytes_left = seg_len - 16'd2;
          walk_st = (bytes_left != 0) ? SegSkip : MarkFirst;
        end
      end
      SegSkip: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) walk_st = MarkFirst;
      end
      SofSkip: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) begin
          bytes_left = 16'd4;
          walk_st = SofDims;
        end
      end
      SofDims: begin
        sof_size = {sof_size[23:0], b};
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) begin
          walk_st = SizeFound;
          walk_done = 1'b1;
        end
      end
      default: walk_done = 1'b1;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input bit f, input bit l);
    int p;
    result_t r;
    if (f) clear_parse();
    p = int'(seen_cnt);
    if (p < 8 && b != PngMagic[63 - 8 * p -: 8]) png_match = 1'b0;
    if (p < 4 && b != RiffTag[31 - 8 * p -: 8]) webp_match = 1'b0;
    if (p >= 8 && p < 12 && b != WebpTag[31 - 8 * (p - 8) -: 8]) webp_match = 1'b0;
    if (p == 0 && b != 8'hFF) jpeg_match = 1'b0;
    if (p == 1 && b != 8'hD8) jpeg_match = 1'b0;
    if (p >= 16 && p < 24) png_size_bytes = {png_size_bytes[55:0], b};
    if (p >= 2 && !walk_done) walk_step(b);
    if (seen_cnt < PosCap) seen_cnt = seen_cnt + 5'd1;
    if (l) begin
      r.fmt = FmtNone;
      r.width = '0;
      r.height = '0;
      if (seen_cnt >= MinBytes) begin
        if (webp_match) begin
          r.fmt = FmtWebp;
        end else if (png_match) begin
          r.fmt = FmtPng;
          if (seen_cnt >= PosCap) begin
            r.width = png_size_bytes[63:32];
            r.height = png_size_bytes[31:0];
          end
        end else if (jpeg_match) begin
          r.fmt = FmtJpeg;
          if (walk_st == SizeFound) begin
            r.height = {16'd0, sof_size[31:16]};
            r.width = {16'd0, sof_size[15:0]};
          end
        end
      end
      pending_reports.push_back(r);
      clear_parse();
    end
  endtask

  // ---------------- drivers ----------------
  task automatic send_beat(input logic [7:0] b, input bit f, input bit l);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= f;
    last_byte_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b, f, l);
    bytes_sent++;
  endtask

  task automatic send_file(input bit mark_first, input bit mark_last);
    int n;
    n = file_buf.size();
    for (int i = 0; i < n; i++) begin
      send_beat(file_buf[i], mark_first && i == 0, mark_last && i == n - 1);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // output stall: short random bursts, or one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with none pending: format %0d width %0d height %0d",
               image_format_o, pixel_width_o, pixel_height_o);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (image_format_o !== want.fmt) begin
          $error("image_format: expected %0d, actual %0d", want.fmt, image_format_o);
          mismatch_count++;
        end
        if (pixel_width_o !== want.width) begin
          $error("pixel_width: expected %0d, actual %0d", want.width, pixel_width_o);
          mismatch_count++;
        end
        if (pixel_height_o !== want.height) begin
          $error("pixel_height: expected %0d, actual %0d", want.height, pixel_height_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- file builders ----------------
  task automatic put_random(input int n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  task automatic put_word(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) file_buf.push_back(v[8 * i +: 8]);
  endtask

  task automatic truncate_buf(input int n);
    while (file_buf.size() > n) void'(file_buf.pop_back());
  endtask

  task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int len);
    file_buf.delete();
    put_word(PngMagic[63:32], 4);
    put_word(PngMagic[31:0], 4);
    put_random(8);
    put_word(w, 4);
    put_word(h, 4);
    if (len > 24) put_random(len - 24);
    truncate_buf(len);
  endtask

  task automatic build_webp(input int len);
    file_buf.delete();
    put_word(RiffTag, 4);
    put_random(4);
    put_word(WebpTag, 4);
    if (len > 12) put_random(len - 12);
    truncate_buf(len);
  endtask

  task automatic start_jpeg();
    file_buf.delete();
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'hD8);
  endtask

  task automatic put_segment(input logic [7:0] code, input int unsigned len);
    file_buf.push_back(8'hFF);
    file_buf.push_back(code);
    file_buf.push_back(len[15:8]);
    file_buf.push_back(len[7:0]);
    if (len >= 2) put_random(len - 2);
  endtask

  // frame header: marker, length and precision, then height and width
  task automatic put_sof(input logic [7:0] code, input logic [15:0] h, input logic [15:0] w);
    file_buf.push_back(8'hFF);
    file_buf.push_back(code);
    put_random(3);
    put_word({16'd0, h}, 2);
    put_word({16'd0, w}, 2);
  endtask

  function automatic logic [7:0] rand_seg_code();
    logic [7:0] c;
    do c = 8'($urandom); while (c >= SofFirst && c <= SofLast);
    return c;
  endfunction

  function automatic logic [31:0] rand_dim32();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_dim16();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic build_clean_jpeg();
    start_jpeg();
    repeat ($urandom_range(0, 3)) put_segment(rand_seg_code(), $urandom_range(2, 12));
    put_sof(8'(SofFirst + $urandom_range(0, 3)), rand_dim16(), rand_dim16());
    put_random($urandom_range(0, 4));
  endtask

  task automatic build_flawed_jpeg();
    logic [7:0] b;
    start_jpeg();
    repeat ($urandom_range(0, 2)) put_segment(rand_seg_code(), $urandom_range(2, 10));
    case ($urandom_range(0, 3))
      0: begin
        // marker lead byte is not FF
        do b = 8'($urandom); while (b == 8'hFF);
        file_buf.push_back(b);
        put_sof(SofFirst, rand_dim16(), rand_dim16());
      end
      1: begin
        // segment length below 2
        file_buf.push_back(8'hFF);
        file_buf.push_back(rand_seg_code());
        file_buf.push_back(8'h00);
        file_buf.push_back(8'($urandom_range(0, 1)));
        put_sof(SofLast, rand_dim16(), rand_dim16());
      end
      2: begin
        put_sof(8'(SofFirst + $urandom_range(0, 3)), rand_dim16(), rand_dim16());
        truncate_buf(file_buf.size() - $urandom_range(1, 8));
      end
      default: begin
        // long segment swallows the rest of the file
        file_buf.push_back(8'hFF);
        file_buf.push_back(rand_seg_code());
        file_buf.push_back(8'($urandom_range(1, 255)));
        file_buf.push_back(8'($urandom));
        put_random($urandom_range(0, 12));
        put_sof(SofFirst, rand_dim16(), rand_dim16());
      end
    endcase
  endtask

  task automatic send_random_file();
    int kind;
    int pos;
    bit mark_first;
    bit mark_last;
    kind = $urandom_range(0, 99);
    mark_first = ($urandom_range(0, 9) != 0);
    mark_last = 1'b1;
    if (kind < 30) begin
      build_clean_jpeg();
    end else if (kind < 45) begin
      build_png(rand_dim32(), rand_dim32(),
                ($urandom_range(0, 4) == 0) ? $urandom_range(12, 23) : $urandom_range(24, 32));
    end else if (kind < 55) begin
      build_webp($urandom_range(12, 24));
    end else if (kind < 75) begin
      build_flawed_jpeg();
    end else if (kind < 85) begin
      file_buf.delete();
      if ($urandom_range(0, 3) == 0) start_jpeg();
      put_random($urandom_range(1, 30));
    end else if (kind < 93) begin
      // one signature bit flipped
      if ($urandom_range(0, 1) == 1) begin
        build_png(rand_dim32(), rand_dim32(), 28);
        pos = $urandom_range(0, 7);
      end else begin
        build_webp(16);
        pos = $urandom_range(0, 7);
        if (pos >= 4) pos = pos + 4;
      end
      file_buf[pos] = file_buf[pos] ^ 8'(1 << $urandom_range(0, 7));
    end else begin
      // file cut off with no last mark; the next file restarts the parse only if it has a first mark
      build_clean_jpeg();
      truncate_buf($urandom_range(1, file_buf.size()));
      mark_last = 1'b0;
    end
    send_file(mark_first, mark_last);
  endtask

  // ---------------- tests ----------------
  task automatic test_short_files();
    file_buf.delete();
    file_buf.push_back(8'hFF);
    send_file(1'b1, 1'b1);
    build_png(32'd16, 32'd16, 11);
    send_file(1'b1, 1'b1);
    file_buf.delete();
    repeat (12) file_buf.push_back(8'h00);
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_webp();
    build_webp(12);
    send_file(1'b1, 1'b1);
    build_webp(30);
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_png();
    build_png(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24);
    send_file(1'b1, 1'b1);
    build_png(32'd0, 32'd0, 30);
    send_file(1'b1, 1'b1);
    build_png(32'd800, 32'd600, 20);
    send_file(1'b1, 1'b1);
    build_png(32'd800, 32'd600, 24);
    file_buf[7] = 8'h0B;
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_jpeg();
    start_jpeg();
    put_segment(8'hFF, 2);
    put_segment(8'hC4, 5);
    put_sof(SofFirst, 16'hFFFF, 16'h0000);
    put_random(3);
    send_file(1'b1, 1'b1);
    start_jpeg();
    put_segment(8'hBF, 3);
    put_sof(SofLast, 16'h0000, 16'hFFFF);
    send_file(1'b1, 1'b1);
    start_jpeg();
    put_sof(8'hC1, 16'd1234, 16'd5678);
    send_file(1'b1, 1'b1);
    start_jpeg();
    put_segment(8'hE0, 4);
    file_buf.push_back(8'h00);
    put_sof(SofFirst, 16'd10, 16'd20);
    send_file(1'b1, 1'b1);
    for (int len = 0; len < 2; len++) begin
      start_jpeg();
      file_buf.push_back(8'hFF);
      file_buf.push_back(8'hE1);
      file_buf.push_back(8'h00);
      file_buf.push_back(8'(len));
      put_sof(SofFirst, 16'd100, 16'd200);
      send_file(1'b1, 1'b1);
    end
    start_jpeg();
    put_segment(8'hDB, 6);
    put_sof(8'hC2, 16'd300, 16'd400);
    truncate_buf(file_buf.size() - 2);
    send_file(1'b1, 1'b1);
    start_jpeg();
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'hE2);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'hFF);
    put_sof(8'hC2, 16'd5, 16'd6);
    put_random(4);
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_framing();
    build_png(32'd640, 32'd480, 24);
    send_file(1'b1, 1'b1);
    build_png(32'd1, 32'd2, 26);
    send_file(1'b0, 1'b1);
    start_jpeg();
    put_segment(8'hE0, 6);
    send_file(1'b1, 1'b0);
    build_webp(16);
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_output_hold();
    in_gaps_on = 1'b0;
    hold_req = 1'b1;
    build_png(32'h1234_5678, 32'h9ABC_DEF0, 28);
    send_file(1'b1, 1'b1);
    repeat (3) begin
      build_clean_jpeg();
      send_file(1'b1, 1'b1);
      build_webp(14);
      send_file(1'b1, 1'b1);
    end
    while (hold_req) @(posedge clk_i);
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_files();
    int stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_file();
    end
  endtask

  task automatic test_steady_stream();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    repeat (10) send_random_file();
    build_png(32'd3, 32'd4, 24);
    send_file(1'b1, 1'b1);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    data_byte_i <= 8'h00;
    first_byte_i <= 1'b0;
    last_byte_i <= 1'b0;
    clear_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_files();
    wait_drain();
    test_webp();
    wait_drain();
    test_png();
    wait_drain();
    test_jpeg();
    wait_drain();
    test_framing();
    wait_drain();
    test_output_hold();
    wait_drain();
    test_random_files();
    wait_drain();
    test_steady_stream();
    wait_drain();
    repeat (8) @(posedge clk_i);

    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: image_header_size_probe_top.f
design/ihsp_pkg.sv
design/ihsp_parser.sv
design/image_header_size_probe_top.sv
tb/image_header_size_probe_top_tb.sv
